### sv/kmp_pkg.sv
package kmp_pkg;

   // field widths fixed by the interface
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int OUT_POS_W = 20;

   // opcodes
   localparam logic OPCODE_PATTERN = 1'b0;
   localparam logic OPCODE_TEXT    = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_STORED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_MATCH    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd4;

   // controller states
   typedef enum logic [0:0] {
      STATE_IDLE,
      STATE_STEP
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // take the input item
      logic advance;  // fall back one step through the failure table
      logic finish;   // write the result and commit state
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;     // compare loop resolved this cycle
      logic out_free; // result register can take a new item
   } ctrl_status_type;

endpackage

### sv/kmp_ram.sv
module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/kmp_controller.sv
module kmp_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  kmp_pkg::ctrl_status_type status,
   output kmp_pkg::ctrl_cmd_type    cmd
);

   kmp_pkg::ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmp_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         kmp_pkg::STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kmp_pkg::STATE_STEP;
            end
         end
         kmp_pkg::STATE_STEP: begin
            if (!status.done) begin
               cmd.advance = 1'b1;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = kmp_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = kmp_pkg::STATE_IDLE;
         end
      endcase
   end

   // an accepted item always moves on to the compare step
   a_load_to_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kmp_pkg::STATE_IDLE && req_valid) |=> state_ff == kmp_pkg::STATE_STEP)
      else $error("accepted item did not enter the compare step");

endmodule

### sv/kmp_datapath.sv
module kmp_datapath #(
   parameter int MAX_PATTERN    = 64,
   parameter int POSITION_WIDTH = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_opcode,
   input  logic [kmp_pkg::BYTE_W-1:0]           req_data_byte,
   input  logic                                 req_first,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [kmp_pkg::STATUS_W-1:0]         rsp_status,
   output logic [kmp_pkg::OUT_POS_W-1:0]        rsp_match_position,
   input  kmp_pkg::ctrl_cmd_type                cmd,
   output kmp_pkg::ctrl_status_type             status
);

   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int ADDR_W = MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1;
   localparam int POS_W  = POSITION_WIDTH;
   localparam int MID_W  = LEN_W > POS_W ? LEN_W : POS_W;
   localparam int CALC_W = MID_W > kmp_pkg::OUT_POS_W ? MID_W : kmp_pkg::OUT_POS_W;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // search state
   logic [LEN_W-1:0] pattern_length_ff, pattern_length_in;
   logic [LEN_W-1:0] build_prefix_ff, build_prefix_in;
   logic [LEN_W-1:0] matched_length_ff, matched_length_in;
   logic [POS_W-1:0] text_position_ff, text_position_in;
   logic             found_ff, found_in;

   // item being worked on
   logic                          cmd_opcode_ff, cmd_opcode_in;
   logic [kmp_pkg::BYTE_W-1:0]    cmd_byte_ff, cmd_byte_in;
   logic [LEN_W-1:0]              cmd_index_ff, cmd_index_in;
   logic [POS_W-1:0]              cmd_pos_ff, cmd_pos_in;
   logic                          direct_ff, direct_in;
   logic [kmp_pkg::STATUS_W-1:0]  direct_status_ff, direct_status_in;
   logic [LEN_W-1:0]              j_ff, j_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [kmp_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [kmp_pkg::OUT_POS_W-1:0] rsp_pos_ff, rsp_pos_in;

   // memories
   logic                       pat_we;
   logic [ADDR_W-1:0]          pat_waddr, pat_raddr;
   logic [kmp_pkg::BYTE_W-1:0] pat_rdata;
   logic                       fail_we;
   logic [ADDR_W-1:0]          fail_waddr, fail_raddr;
   logic [LEN_W-1:0]           fail_wdata, fail_rdata;

   // load-time values
   logic             pat_first;
   logic [LEN_W-1:0] len_e, bp_e, ml_e, j0_pat, j0_txt, j0;
   logic [POS_W-1:0] tp_e;
   logic             found_e, overflow, first_byte;
   logic             load_direct;
   logic [kmp_pkg::STATUS_W-1:0] load_status;

   // step-time values
   logic              eq, done;
   logic [LEN_W-1:0]  jn, rd_sel, rd_sel_m1;
   logic [CALC_W-1:0] idx_ext, mm1, start_pos;

   kmp_ram #(.WIDTH(kmp_pkg::BYTE_W), .DEPTH(MAX_PATTERN)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_waddr),
      .wr_data (cmd.load ? req_data_byte : cmd_byte_ff),
      .rd_addr (pat_raddr),
      .rd_data (pat_rdata)
   );

   kmp_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERN)) u_failure_ram (
      .clock   (clock),
      .wr_en   (fail_we),
      .wr_addr (fail_waddr),
      .wr_data (fail_wdata),
      .rd_addr (fail_raddr),
      .rd_data (fail_rdata)
   );

   // state as seen by the incoming item, after any restart
   always_comb begin
      pat_first  = req_first && (req_opcode == kmp_pkg::OPCODE_PATTERN);
      len_e      = pat_first ? '0 : pattern_length_ff;
      bp_e       = pat_first ? '0 : build_prefix_ff;
      ml_e       = req_first ? '0 : matched_length_ff;
      tp_e       = req_first ? '0 : text_position_ff;
      found_e    = req_first ? 1'b0 : found_ff;
      overflow   = len_e >= MAX_LEN;
      first_byte = len_e == '0;
      j0_pat     = (bp_e >= len_e) ? '0 : bp_e;
      j0_txt     = (ml_e >= pattern_length_ff) ? '0 : ml_e;
      if (req_opcode == kmp_pkg::OPCODE_PATTERN) begin
         j0          = j0_pat;
         load_direct = overflow || first_byte;
         load_status = overflow ? kmp_pkg::STATUS_OVERFLOW : kmp_pkg::STATUS_STORED;
      end else begin
         j0          = j0_txt;
         load_direct = found_e || (pattern_length_ff == '0);
         load_status = found_e ? kmp_pkg::STATUS_ALREADY : kmp_pkg::STATUS_NO_MATCH;
      end
   end

   // one compare step on the registered read data
   always_comb begin
      eq   = pat_rdata == cmd_byte_ff;
      done = direct_ff || (j_ff == '0) || eq;
      jn   = j_ff + LEN_W'(eq);
   end

   assign status.done     = done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // read address: start point, fallback target, or hold
   always_comb begin
      if (cmd.load) begin
         rd_sel = j0;
      end else if (cmd.advance) begin
         rd_sel = fail_rdata;
      end else begin
         rd_sel = j_ff;
      end
      rd_sel_m1  = rd_sel - LEN_W'(1);
      pat_raddr  = rd_sel[ADDR_W-1:0];
      fail_raddr = rd_sel_m1[ADDR_W-1:0];
   end

   // start index of a match, clamped at zero for a saturated position
   always_comb begin
      idx_ext   = CALC_W'(cmd_pos_ff);
      mm1       = CALC_W'(pattern_length_ff) - CALC_W'(1);
      start_pos = (idx_ext >= mm1) ? idx_ext - mm1 : '0;
   end

   // store writes
   always_comb begin
      pat_we     = cmd.load && (req_opcode == kmp_pkg::OPCODE_PATTERN) && !overflow;
      pat_waddr  = len_e[ADDR_W-1:0];
      fail_we    = 1'b0;
      fail_waddr = '0;
      fail_wdata = '0;
      if (cmd.load && (req_opcode == kmp_pkg::OPCODE_PATTERN) && !overflow && first_byte) begin
         fail_we = 1'b1;
      end else if (cmd.finish && !direct_ff && (cmd_opcode_ff == kmp_pkg::OPCODE_PATTERN)) begin
         fail_we    = 1'b1;
         fail_waddr = cmd_index_ff[ADDR_W-1:0];
         fail_wdata = jn;
      end
   end

   // next-state logic
   always_comb begin
      pattern_length_in = pattern_length_ff;
      build_prefix_in   = build_prefix_ff;
      matched_length_in = matched_length_ff;
      text_position_in  = text_position_ff;
      found_in          = found_ff;
      cmd_opcode_in     = cmd_opcode_ff;
      cmd_byte_in       = cmd_byte_ff;
      cmd_index_in      = cmd_index_ff;
      cmd_pos_in        = cmd_pos_ff;
      direct_in         = direct_ff;
      direct_status_in  = direct_status_ff;
      j_in              = j_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_pos_in        = rsp_pos_ff;

      if (cmd.load) begin
         cmd_opcode_in     = req_opcode;
         cmd_byte_in       = req_data_byte;
         cmd_index_in      = len_e;
         cmd_pos_in        = tp_e;
         direct_in         = load_direct;
         direct_status_in  = load_status;
         j_in              = j0;
         build_prefix_in   = bp_e;
         matched_length_in = ml_e;
         found_in          = found_e;
         text_position_in  = tp_e;
         pattern_length_in = len_e;
         if (req_opcode == kmp_pkg::OPCODE_PATTERN) begin
            if (!overflow) begin
               pattern_length_in = len_e + LEN_W'(1);
               if (first_byte) begin
                  build_prefix_in = '0;
               end
            end
         end else if (tp_e != POS_MAX) begin
            text_position_in = tp_e + POS_W'(1);
         end
      end

      if (cmd.advance) begin
         j_in = fail_rdata;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = '0;
         if (direct_ff) begin
            rsp_status_in = direct_status_ff;
         end else if (cmd_opcode_ff == kmp_pkg::OPCODE_PATTERN) begin
            rsp_status_in   = kmp_pkg::STATUS_STORED;
            build_prefix_in = jn;
         end else if (jn == pattern_length_ff) begin
            rsp_status_in     = kmp_pkg::STATUS_MATCH;
            rsp_pos_in        = start_pos[kmp_pkg::OUT_POS_W-1:0];
            found_in          = 1'b1;
            matched_length_in = '0;
         end else begin
            rsp_status_in     = kmp_pkg::STATUS_NO_MATCH;
            matched_length_in = jn;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         build_prefix_ff   <= '0;
         matched_length_ff <= '0;
         text_position_ff  <= '0;
         found_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         build_prefix_ff   <= build_prefix_in;
         matched_length_ff <= matched_length_in;
         text_position_ff  <= text_position_in;
         found_ff          <= found_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_opcode_ff    <= cmd_opcode_in;
      cmd_byte_ff      <= cmd_byte_in;
      cmd_index_ff     <= cmd_index_in;
      cmd_pos_ff       <= cmd_pos_in;
      direct_ff        <= direct_in;
      direct_status_ff <= direct_status_in;
      j_ff             <= j_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_pos_ff       <= rsp_pos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_match_position = rsp_pos_ff;

   // once a match is reported the matched prefix is parked at zero
   a_found_clears_prefix: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> matched_length_ff == '0)
      else $error("matched prefix not cleared after a match");

   // table build prefix stays below the stored length
   a_prefix_below_length: assert property (@(posedge clock) disable iff (reset)
      (build_prefix_ff < pattern_length_ff) ||
      (build_prefix_ff == '0 && pattern_length_ff == '0))
      else $error("build prefix out of range");

   // only a completed match carries a position
   a_position_only_on_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != kmp_pkg::STATUS_MATCH) |-> rsp_pos_ff == '0)
      else $error("position reported without a match");

endmodule

### sv/kmp_stream_matcher_core.sv
// Streaming Knuth-Morris-Pratt matcher.
// Input channel (req_*): one byte per item. opcode 0 loads a pattern byte and
// extends the failure table; opcode 1 scans a text byte. first = 1 starts a
// new pattern, or restarts the text search at position 0.
// Result channel (rsp_*): exactly one item per input item, in order, with a
// status code and, for a completed match, the start index in the text.
// Sequence: an item is accepted in the idle state, then enters the compare
// step, which falls back through the failure table until the compare
// resolves; the result register loads at the end of the final compare step.
// A new item is accepted only after the previous item has loaded its
// result, when the controller is back in the idle state.
// The read latency of the pattern and failure RAMs sets the one-step-per-cycle
// compare loop.
// Stall: the result sits in its register until taken; the next item may be
// accepted meanwhile, and its final compare step holds until the register frees.
// Reset: pattern length, table build, matched prefix, text position and the
// match flag clear. The RAMs are not cleared; entries are only read once written.
module kmp_stream_matcher_core #(
   parameter int MAX_PATTERN    = 64,
   parameter int POSITION_WIDTH = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [kmp_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                          req_first,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kmp_pkg::STATUS_W-1:0]  rsp_status,
   output logic [kmp_pkg::OUT_POS_W-1:0] rsp_match_position
);

   kmp_pkg::ctrl_cmd_type    cmd;
   kmp_pkg::ctrl_status_type status;

   kmp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kmp_datapath #(
      .MAX_PATTERN    (MAX_PATTERN),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_data_byte      (req_data_byte),
      .req_first          (req_first),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_match_position (rsp_match_position),
      .cmd                (cmd),
      .status             (status)
   );

endmodule
